// File: rtl/hhe_pkg.sv
package hhe_pkg;

	localparam int NAME_DEPTH_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam int MIN_PACKET  = 40;
	localparam int MIN_TCP     = 20;
	localparam int TCP_OFS_IDX = 12;
	localparam int MARK_LEN    = 6;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_H  = 8'h48;

	typedef struct packed {
		logic take;
		logic eval;
		logic trim_rd;
		logic trim_dec;
		logic emit_rd;
		logic emit_load;
		logic none_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic eval_cut;
		logic eval_zero;
		logic rd_trim;
		logic len_one;
		logic k_last;
		logic out_free;
	} stat_t;

	// "Host: "
	function automatic logic [7:0] mark_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h48;
			3'd1: c = 8'h6F;
			3'd2: c = 8'h73;
			3'd3: c = 8'h74;
			3'd4: c = 8'h3A;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/http_host_header_extractor_core.sv
// Host name extractor for IPv4/TCP packets.
// Input channel: one packet byte per item (data_byte, end_of_packet on the last
// byte), with in_valid / in_stall. Bytes are taken one per cycle while parsing.
// Output channel: one item per host name byte (host_byte, last_of_name,
// name_found, name_truncated) with out_valid / out_stall, or a single no-name
// item (host_byte 0, last_of_name 1) when no name is extracted.
// After the end-of-packet byte, in_stall is high while the name is evaluated and
// sent: an evaluation step; unless the name was cut, a read and a check of each
// trailing CR or space trimmed and of the last kept byte; then per name byte a
// read from the name store and a load of the output register. A no-name item
// follows evaluation, or the trimming if it removed the whole name. The next
// packet's first byte is taken as soon as the final item sits in the output
// register. A stalled receiver holds the output register and the emission waits.
// Reset (arst_n low, asynchronous) clears all packet state and the output valid;
// the name store itself is not cleared and needs no clearing pass.
module http_host_header_extractor_core #(
	parameter int NAME_DEPTH = hhe_pkg::NAME_DEPTH_DEF,
	parameter int COUNT_BITS = hhe_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_packet,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] host_byte,
	output logic       last_of_name,
	output logic       name_found,
	output logic       name_truncated
);

	import hhe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hhe_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.end_of_packet (end_of_packet),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.stat          (stat)
	);

	hhe_datapath #(
		.NAME_DEPTH (NAME_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.host_byte      (host_byte),
		.last_of_name   (last_of_name),
		.name_found     (name_found),
		.name_truncated (name_truncated)
	);

	a_eop_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && end_of_packet) |=> in_stall)
		else $error("input taken right after end of packet");

	a_no_name_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !name_found) |-> (last_of_name && host_byte == 8'h00 && !name_truncated))
		else $error("malformed no-name item");

	a_trunc_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && name_truncated) |-> name_found)
		else $error("truncated flag without a name");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take && (cmd.emit_load || cmd.none_load || cmd.eval)))
		else $error("input taken during evaluation or emission");

endmodule

// File: rtl/hhe_ram.sv
module hhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/hhe_datapath.sv
module hhe_datapath #(
	parameter int NAME_DEPTH = hhe_pkg::NAME_DEPTH_DEF,
	parameter int COUNT_BITS = hhe_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    data_byte,
	input  hhe_pkg::cmd_t cmd,
	output hhe_pkg::stat_t stat,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [7:0]    host_byte,
	output logic          last_of_name,
	output logic          name_found,
	output logic          name_truncated
);

	import hhe_pkg::*;

	localparam int AW = $clog2(NAME_DEPTH);
	localparam int SW = $clog2(NAME_DEPTH + 1);
	localparam int CW = COUNT_BITS;
	localparam logic [CW-1:0] CNT_MAX = '1;
	localparam logic [SW-1:0] DEPTH_S = SW'(NAME_DEPTH);

	logic [CW-1:0] bc_q;
	logic [5:0]    ip_q;
	logic [5:0]    tcp_q;
	logic          tcp_known_q;
	logic [2:0]    match_q;
	logic          capturing_q;
	logic [SW-1:0] stored_q;
	logic [CW-1:0] cap_len_q;
	logic [CW-1:0] crlf_pos_q;
	logic          crlf_seen_q;
	logic [CW-1:0] lf_pos_q;
	logic          lf_seen_q;
	logic [CW-1:0] over_pos_q;
	logic          over_seen_q;
	logic          prev_cr_q;
	logic [SW-1:0] len_q;
	logic [AW-1:0] k_q;
	logic          cut_q;
	logic          out_valid_q;

	logic [7:0]    hdr_end;
	logic [7:0]    tcp_at;
	logic          tcp_ok;
	logic          search_en;
	logic          cap_en;
	logic          is_lf;
	logic          is_trim;
	logic          crlf_hit;
	logic          store_en;
	logic          mark_hit;
	logic          ok;
	logic [CW-1:0] end_pos;
	logic          cut_now;
	logic [SW-1:0] n0;
	logic [SW-1:0] eval_len;
	logic [SW-1:0] len_m1;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign hdr_end   = 8'(ip_q) + 8'(tcp_q);
	assign tcp_at    = 8'(ip_q) + 8'(TCP_OFS_IDX);
	assign tcp_ok    = tcp_known_q && (tcp_q >= 6'(MIN_TCP));
	assign search_en = !capturing_q && tcp_ok && (bc_q >= CW'(hdr_end));
	assign cap_en    = capturing_q && !crlf_seen_q;
	assign is_lf     = (data_byte == CH_LF);
	assign is_trim   = (data_byte == CH_CR) || (data_byte == CH_SP);
	assign crlf_hit  = is_lf && prev_cr_q && (cap_len_q != '0);
	assign store_en  = cmd.take && cap_en && !crlf_hit && (stored_q < DEPTH_S);
	assign mark_hit  = (data_byte == mark_char(match_q));

	// end of packet evaluation
	assign ok = (bc_q >= CW'(MIN_PACKET)) && tcp_ok && (CW'(hdr_end) < bc_q) && capturing_q;
	assign end_pos = crlf_seen_q ? crlf_pos_q : (lf_seen_q ? lf_pos_q : cap_len_q);
	assign cut_now = ok && over_seen_q && (over_pos_q < end_pos);
	assign n0 = (end_pos < CW'(stored_q)) ? end_pos[SW-1:0] : stored_q;
	assign eval_len = cut_now ? stored_q : (ok ? n0 : '0);

	assign len_m1  = len_q - SW'(1);
	assign rd_en   = cmd.trim_rd || cmd.emit_rd;
	assign rd_addr = cmd.trim_rd ? len_m1[AW-1:0] : k_q;

	assign stat.eval_cut  = cut_now;
	assign stat.eval_zero = (eval_len == '0);
	assign stat.rd_trim   = (rd_data == CH_CR) || (rd_data == CH_SP);
	assign stat.len_one   = (len_q == SW'(1));
	assign stat.k_last    = ((SW'(k_q) + SW'(1)) == len_q);
	assign stat.out_free  = !out_valid_q || !out_stall;

	hhe_ram #(
		.WIDTH(8),
		.DEPTH(NAME_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (store_en),
		.wr_addr (stored_q[AW-1:0]),
		.wr_data (data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= '0;
			ip_q        <= '0;
			tcp_q       <= '0;
			tcp_known_q <= 1'b0;
			match_q     <= '0;
			capturing_q <= 1'b0;
			stored_q    <= '0;
			cap_len_q   <= '0;
			crlf_pos_q  <= '0;
			crlf_seen_q <= 1'b0;
			lf_pos_q    <= '0;
			lf_seen_q   <= 1'b0;
			over_pos_q  <= '0;
			over_seen_q <= 1'b0;
			prev_cr_q   <= 1'b0;
		end else if (cmd.clear) begin
			bc_q        <= '0;
			ip_q        <= '0;
			tcp_q       <= '0;
			tcp_known_q <= 1'b0;
			match_q     <= '0;
			capturing_q <= 1'b0;
			stored_q    <= '0;
			cap_len_q   <= '0;
			crlf_pos_q  <= '0;
			crlf_seen_q <= 1'b0;
			lf_pos_q    <= '0;
			lf_seen_q   <= 1'b0;
			over_pos_q  <= '0;
			over_seen_q <= 1'b0;
			prev_cr_q   <= 1'b0;
		end else if (cmd.take) begin
			if (bc_q != CNT_MAX) begin
				bc_q <= bc_q + CW'(1);
			end
			if (bc_q == '0) begin
				ip_q <= {data_byte[3:0], 2'b00};
			end else if (!tcp_known_q && (bc_q == CW'(tcp_at))) begin
				tcp_q       <= {data_byte[7:4], 2'b00};
				tcp_known_q <= 1'b1;
			end
			if (cap_en) begin
				if (crlf_hit) begin
					crlf_pos_q  <= cap_len_q - CW'(1);
					crlf_seen_q <= 1'b1;
				end else begin
					if (is_lf && !lf_seen_q) begin
						lf_pos_q  <= cap_len_q;
						lf_seen_q <= 1'b1;
					end
					if (stored_q < DEPTH_S) begin
						stored_q <= stored_q + SW'(1);
					end else if (!over_seen_q && !is_trim) begin
						over_pos_q  <= cap_len_q;
						over_seen_q <= 1'b1;
					end
					prev_cr_q <= (data_byte == CH_CR);
					if (cap_len_q != CNT_MAX) begin
						cap_len_q <= cap_len_q + CW'(1);
					end
				end
			end else if (search_en) begin
				if (mark_hit) begin
					if (match_q == 3'(MARK_LEN - 1)) begin
						match_q     <= '0;
						capturing_q <= 1'b1;
					end else begin
						match_q <= match_q + 3'd1;
					end
				end else begin
					match_q <= (data_byte == CH_H) ? 3'd1 : 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			k_q   <= '0;
			cut_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				len_q <= eval_len;
				cut_q <= cut_now;
			end else if (cmd.trim_dec) begin
				len_q <= len_m1;
			end
			if (cmd.clear) begin
				k_q <= '0;
			end else if (cmd.emit_load) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.none_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			host_byte      <= rd_data;
			last_of_name   <= stat.k_last;
			name_found     <= 1'b1;
			name_truncated <= cut_q;
		end else if (cmd.none_load) begin
			host_byte      <= 8'h00;
			last_of_name   <= 1'b1;
			name_found     <= 1'b0;
			name_truncated <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/hhe_ctrl.sv
module hhe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           end_of_packet,
	output logic           in_stall,
	output hhe_pkg::cmd_t  cmd,
	input  hhe_pkg::stat_t stat
);

	import hhe_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EVAL     = 3'd1;
	localparam logic [2:0] S_TRIM_RD  = 3'd2;
	localparam logic [2:0] S_TRIM_CHK = 3'd3;
	localparam logic [2:0] S_EMIT_RD  = 3'd4;
	localparam logic [2:0] S_EMIT_WR  = 3'd5;
	localparam logic [2:0] S_NONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (end_of_packet) begin
						state_d = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.eval_cut) begin
					state_d = S_EMIT_RD;
				end else if (stat.eval_zero) begin
					state_d = S_NONE;
				end else begin
					state_d = S_TRIM_RD;
				end
			end
			S_TRIM_RD: begin
				cmd.trim_rd = 1'b1;
				state_d     = S_TRIM_CHK;
			end
			S_TRIM_CHK: begin
				if (stat.rd_trim) begin
					cmd.trim_dec = 1'b1;
					state_d      = stat.len_one ? S_NONE : S_TRIM_RD;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					if (stat.k_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_EMIT_RD;
					end
				end
			end
			S_NONE: begin
				if (stat.out_free) begin
					cmd.none_load = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
